// ----- rtl/aesctr_pkg.sv -----
// Shared types, constants and AES helper functions for the AES-128 CTR block.
// No dependencies.
package aesctr_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CountW    = 5;
  localparam int unsigned InDataW   = 197;  // 64+64+64+5
  localparam int unsigned InTdataW  = 200;
  localparam int unsigned OutDataW  = 133;
  localparam int unsigned OutTdataW = 136;

  localparam logic [CfgIdxW-1:0] CfgKeyLow   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNonce    = 2'd2;

  typedef logic [127:0] block_t;
  typedef logic [NumRounds:0][127:0] rkeys_t;

  // Side data carried alongside the cipher state
  typedef struct packed {
    logic [127:0]      data;
    logic [CountW-1:0] count;
  } side_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes + ShiftRows, byte i at bits 8i+7:8i, byte r+4c = row r col c
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ all ^ gf_double(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ all ^ gf_double(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // One key-schedule round: previous round key and rcon give the next
  function automatic block_t key_round(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    block_t n;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    key_round = n;
  endfunction

endpackage

// ----- rtl/aesctr_keysched.sv -----
// Sequential AES-128 key expansion into a round-key register bank.
// Depends on aesctr_pkg. Takes one round per cycle after a key write or reset.
module aesctr_keysched (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  aesctr_pkg::block_t   key_i,
  output aesctr_pkg::rkeys_t   rkeys_o
);
  import aesctr_pkg::*;

  logic [3:0]  round_q, round_d;
  logic [7:0]  rc_q, rc_d;
  logic        busy_q, busy_d;
  rkeys_t      rk_q, rk_d;

  // Expansion step: round r built from round r-1
  always_comb begin
    round_d = round_q;
    rc_d    = rc_q;
    busy_d  = busy_q;
    rk_d    = rk_q;
    if (start_i) begin
      rk_d[0] = key_i;
      round_d = 4'd1;
      rc_d    = 8'h01;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      rk_d[round_q] = key_round(rk_q[round_q - 4'd1], rc_q);
      rc_d          = gf_double(rc_q);
      round_d       = round_q + 4'd1;
      busy_d        = (round_q != 4'(NumRounds));
    end
  end

  // Reset starts expansion of the all-zero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= 4'd1;
      rc_q    <= 8'h01;
      busy_q  <= 1'b1;
      rk_q    <= '0;
    end else begin
      round_q <= round_d;
      rc_q    <= rc_d;
      busy_q  <= busy_d;
      rk_q    <= rk_d;
    end
  end

  assign rkeys_o = rk_q;
endmodule

// ----- rtl/aesctr_round.sv -----
// One registered AES round stage with stall control, carrying side data.
// Depends on aesctr_pkg.
module aesctr_round #(
  parameter bit FirstRound = 1'b0,
  parameter bit LastRound  = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  aesctr_pkg::block_t  state_i,
  input  aesctr_pkg::side_t   side_i,
  input  aesctr_pkg::block_t  rkey_i,
  output logic                valid_o,
  output aesctr_pkg::block_t  state_o,
  output aesctr_pkg::side_t   side_o
);
  import aesctr_pkg::*;

  block_t state_d, state_q;
  side_t  side_q;
  logic   valid_q;

  // Round function
  always_comb begin
    if (FirstRound) begin
      state_d = state_i ^ rkey_i;
    end else if (LastRound) begin
      state_d = sub_shift(state_i) ^ rkey_i;
    end else begin
      state_d = mix_columns(sub_shift(state_i)) ^ rkey_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign side_o  = side_q;
endmodule

// ----- rtl/aes128_ctr_keystream_xor.sv -----
// AES-128 counter-mode keystream XOR, top level.
// Datapath: 11 registered round stages followed by an output register.
// Throughput: one item per cycle; the unrolled round pipeline stalls as a whole on output backpressure.
// Reset: control cleared; key and nonce zero; the zero key expands with input held.
// A key write holds input off while the key expansion starts and runs; a nonce write also holds input off.
module aes128_ctr_keystream_xor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // data_low[63:0], data_high[127:64], block_index[191:128], valid_bytes[196:192], zero pad
  input  logic [aesctr_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_low[63:0], result_high[127:64], result_valid_bytes[132:128], zero pad
  output logic [aesctr_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aesctr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);
  import aesctr_pkg::*;

  logic [63:0] key_lo_q, key_hi_q, nonce_q;
  logic        cfg_we, key_we_q;
  logic [3:0]  hold_q;
  rkeys_t      rkeys;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      nonce_q  <= '0;
      key_we_q <= 1'b0;
    end else begin
      key_we_q <= cfg_we && (cfg_index_i == CfgKeyLow || cfg_index_i == CfgKeyHigh);
      if (cfg_we) begin
        unique case (cfg_index_i)
          CfgKeyLow:  key_lo_q <= cfg_data_i;
          CfgKeyHigh: key_hi_q <= cfg_data_i;
          CfgNonce:   nonce_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Input hold-off while round keys expand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 4'(NumRounds);
    end else if (key_we_q || cfg_we) begin
      hold_q <= 4'(NumRounds + 1);
    end else if (hold_q != 4'd0) begin
      hold_q <= hold_q - 4'd1;
    end
  end

  aesctr_keysched u_keysched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (key_we_q),
    .key_i   ({key_hi_q, key_lo_q}),
    .rkeys_o (rkeys)
  );

  // Pipeline: stalls whole when output register is full and not drained
  logic   out_valid_q;
  logic   en;
  logic   [NumRounds+1:0] v;
  block_t [NumRounds+1:0] st;
  side_t  [NumRounds+1:0] sd;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en && (hold_q == 4'd0) && !cfg_valid_i;

  assign v[0]  = s_axis_tvalid && s_axis_tready;
  assign st[0] = {s_axis_tdata[191:128], nonce_q};
  assign sd[0] = '{data: s_axis_tdata[127:0], count: s_axis_tdata[196:192]};

  for (genvar r = 0; r <= NumRounds; r++) begin : g_round
    aesctr_round #(
      .FirstRound (r == 0),
      .LastRound  (r == NumRounds)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[r]),
      .state_i (st[r]),
      .side_i  (sd[r]),
      .rkey_i  (rkeys[r]),
      .valid_o (v[r+1]),
      .state_o (st[r+1]),
      .side_o  (sd[r+1])
    );
  end

  // Keystream XOR with byte masking into output register
  logic [OutDataW-1:0] res_d, res_q;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res_d[8*i +: 8] = (5'(i) < sd[NumRounds+1].count)
          ? (sd[NumRounds+1].data[8*i +: 8] ^ st[NumRounds+1][8*i +: 8]) : 8'h00;
    end
    res_d[132:128] = sd[NumRounds+1].count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[NumRounds+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-OutDataW){1'b0}}, res_q};
endmodule

// ----- rtl/aesctr_checker.sv -----
// Port-level checker for the AES-128 CTR top level, with its bind.
// Depends on aesctr_pkg.
module aesctr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [aesctr_pkg::OutTdataW-1:0]   m_axis_tdata,
  input logic                               cfg_valid_i
);
  import aesctr_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // Pad bits zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutTdataW-1:OutDataW] == '0)
    else $error("pad bits set");

  // No input taken during a config write
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !s_axis_tready)
    else $error("input accepted during config write");

  // Input held off right after a config write
  a_keyhold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !s_axis_tready)
    else $error("input accepted during key expansion");
endmodule

bind aes128_ctr_keystream_xor aesctr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i)
);
